@@ rtl/per_client_token_bucket_limiter_core_macros.svh @@
// assertion macros shared by the token bucket limiter checkers
`ifndef PER_CLIENT_TOKEN_BUCKET_LIMITER_CORE_MACROS_SVH
`define PER_CLIENT_TOKEN_BUCKET_LIMITER_CORE_MACROS_SVH

// property checked on every clock edge outside reset
`define PCTBL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define PCTBL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/pctbl_pkg.sv @@
// types, constants and helpers of the per-client token bucket limiter
package pctbl_pkg;

  // client table geometry
  localparam int unsigned TABLE_SLOTS = 64;
  localparam int unsigned SLOT_IDX_W  = $clog2(TABLE_SLOTS);
  localparam int unsigned SLOT_CNT_W  = $clog2(TABLE_SLOTS + 1);

  // field widths
  localparam int unsigned CLIENT_W     = 17;
  localparam int unsigned CLIENT_KEY_W = 16;
  localparam int unsigned TIME_W       = 64;
  localparam int unsigned TOKEN_W      = 46;
  localparam int unsigned RATE_W       = 20;
  localparam int unsigned BURST_W      = 16;

  // stream and config port widths
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 20;

  // nano-tokens
  localparam logic [TOKEN_W-1:0] NANO_PER_TOKEN = 46'd1000000000;
  localparam logic [RATE_W-1:0]  RATE_RESET     = 20'd100;
  localparam logic [BURST_W-1:0] BURST_RESET    = 16'd100;
  localparam logic [TOKEN_W-1:0] CAP_RESET      = 46'd100000000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 2'd0,
    CFG_RATE  = 2'd1,
    CFG_BURST = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHARED,
    ST_BUCKET,
    ST_RESP
  } ctl_state_e;

  typedef enum logic [2:0] {
    RF_IDLE,
    RF_LO,
    RF_HI,
    RF_SUM,
    RF_CAP,
    RF_TAKE
  } refill_phase_e;

  typedef struct packed {
    logic [CLIENT_KEY_W-1:0] client;
    logic [TOKEN_W-1:0]      tokens;
    logic [TIME_W-1:0]       last;
  } slot_entry_t;

  localparam int unsigned ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    logic [TOKEN_W-1:0] tokens;
    logic [TIME_W-1:0]  last;
    logic [TIME_W-1:0]  now;
  } refill_req_t;

  typedef struct packed {
    logic               granted;
    logic [TOKEN_W-1:0] tokens;
    logic [TIME_W-1:0]  last;
  } refill_res_t;

  // bucket capacity in nano-tokens, zero burst acts as one
  function automatic logic [TOKEN_W-1:0] cap_from_burst(input logic [BURST_W-1:0] burst);
    logic [BURST_W-1:0] b;
    b = (burst == '0) ? BURST_W'(1) : burst;
    return TOKEN_W'(b) * NANO_PER_TOKEN;
  endfunction

endpackage

@@ rtl/pctbl_ram.sv @@
// simple dual-port ram, one write and one registered read port
module pctbl_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 8,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ rtl/pctbl_refill.sv @@
// bucket refill and token take unit, one shared 32x20 multiplier
module pctbl_refill import pctbl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  refill_req_t        req_i,
  input  logic [RATE_W-1:0]  rate_i,
  input  logic [TOKEN_W-1:0] cap_i,
  output logic               done_o,
  output refill_res_t        res_o
);

  localparam int unsigned HALF_W = TIME_W / 2;
  localparam int unsigned PROD_W = HALF_W + RATE_W;
  localparam int unsigned ACC_W  = PROD_W + 1;
  localparam int unsigned SUM_W  = PROD_W + HALF_W + 1;

  refill_phase_e phase_q, phase_d;

  logic [TIME_W-1:0]  elapsed_q;
  logic               adv_q;
  logic [TOKEN_W-1:0] tok_q;
  logic [TIME_W-1:0]  last_new_q;
  logic [PROD_W-1:0]  lo_q;
  logic [PROD_W-1:0]  hi_q;
  logic [ACC_W-1:0]   acc_q;
  logic [SUM_W-1:0]   sum_q;
  logic [TOKEN_W-1:0] fill_q;

  logic [HALF_W-1:0]  mul_a;
  logic [PROD_W-1:0]  mul_p;
  logic               take;

  assign mul_a = (phase_q == RF_LO) ? elapsed_q[HALF_W-1:0] : elapsed_q[TIME_W-1:HALF_W];
  assign mul_p = PROD_W'(mul_a) * PROD_W'(rate_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= RF_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      RF_IDLE: if (start_i) phase_d = RF_LO;
      RF_LO:   phase_d = RF_HI;
      RF_HI:   phase_d = RF_SUM;
      RF_SUM:  phase_d = RF_CAP;
      RF_CAP:  phase_d = RF_TAKE;
      RF_TAKE: phase_d = RF_IDLE;
      default: phase_d = RF_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      RF_IDLE: begin
        if (start_i) begin
          elapsed_q  <= req_i.now - req_i.last;
          adv_q      <= req_i.now > req_i.last;
          tok_q      <= req_i.tokens;
          last_new_q <= (req_i.now > req_i.last) ? req_i.now : req_i.last;
        end
      end
      RF_LO: lo_q <= mul_p;
      RF_HI: begin
        hi_q  <= mul_p;
        acc_q <= ACC_W'(lo_q) + ACC_W'(tok_q);
      end
      RF_SUM: sum_q <= {1'b0, hi_q, HALF_W'(0)} + SUM_W'(acc_q);
      // saturate at the cap, no refill when time did not advance
      RF_CAP: begin
        if (!adv_q) begin
          fill_q <= tok_q;
        end else if (sum_q > SUM_W'(cap_i)) begin
          fill_q <= cap_i;
        end else begin
          fill_q <= sum_q[TOKEN_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign take         = fill_q >= NANO_PER_TOKEN;
  assign done_o       = (phase_q == RF_TAKE);
  assign res_o.granted = take;
  assign res_o.tokens  = take ? (fill_q - NANO_PER_TOKEN) : fill_q;
  assign res_o.last    = last_new_q;

endmodule

@@ rtl/per_client_token_bucket_limiter_core.sv @@
// Token bucket admission limiter: each request (client id, nanosecond timestamp) is answered
// with one grant/deny transaction. With per_client_mode clear a single shared bucket is used.
// With per_client_mode set, a negative id is granted without touching state; otherwise the
// low id bits give the start slot and the whole slot table is scanned at one ram read per
// cycle, stopping early when the client is found. The table memory has a single read port.
// One request is worked on at a time; the next one is taken while the previous result still
// waits in the output register. A new client gets the first empty slot in probe order, or
// when the table is full the slot holding the most tokens (first in probe order on ties); it
// starts with a full bucket and is always granted. Slot valid bits sit in flip-flops cleared
// by reset, so the block is ready right after reset. Configuration is taken at any time
// through the cfg port but must only be written while no request is in flight.
module per_client_token_bucket_limiter_core import pctbl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request: [16:0] client_id (signed), [80:17] now_ns, rest zero
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  // result: [0] granted, rest zero
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // register write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration registers and derived values
  logic               mode_q;
  logic [RATE_W-1:0]  rate_q;
  logic [BURST_W-1:0] burst_q;
  logic [RATE_W-1:0]  rate_eff_q;
  logic [TOKEN_W-1:0] cap_q;

  // shared bucket
  logic [TOKEN_W-1:0] shared_tok_q;
  logic [TIME_W-1:0]  shared_last_q;

  // request in flight
  ctl_state_e state_q, state_d;
  logic                       item_pc_q;
  logic signed [CLIENT_W-1:0] id_q;
  logic [TIME_W-1:0]          now_q;

  // table scan
  logic [TABLE_SLOTS-1:0] used_q;
  logic [SLOT_IDX_W-1:0]  probe_q;
  logic [SLOT_IDX_W-1:0]  probe_nxt;
  logic [SLOT_CNT_W-1:0]  issue_cnt_q;
  logic [SLOT_CNT_W-1:0]  cmp_cnt_q;
  logic                   rd_vld_q;
  logic [SLOT_IDX_W-1:0]  rd_slot_q;
  logic                   rd_used_q;
  logic                   have_empty_q;
  logic [SLOT_IDX_W-1:0]  empty_slot_q;
  logic                   have_best_q;
  logic [TOKEN_W-1:0]     best_tok_q;
  logic [SLOT_IDX_W-1:0]  best_slot_q;
  logic [SLOT_IDX_W-1:0]  tgt_q;
  logic [SLOT_IDX_W-1:0]  new_slot;

  logic [ENTRY_W-1:0] ram_rdata;
  slot_entry_t        rd_entry;
  slot_entry_t        ram_wdata;
  logic               ram_we;

  logic scan_issue;
  logic scan_cmp;
  logic hit;
  logic scan_last;
  logic empty_take;
  logic best_take;

  // refill unit
  logic        rf_start;
  refill_req_t rf_req;
  logic        rf_done;
  refill_res_t rf_res;

  // result
  logic res_grant_q;
  logic out_valid_q;
  logic out_grant_q;
  logic out_load;

  logic                       accept_in;
  logic signed [CLIENT_W-1:0] in_client;
  logic [TIME_W-1:0]          in_now;

  assign in_client = s_axis_tdata[CLIENT_W-1:0];
  assign in_now    = s_axis_tdata[CLIENT_W+TIME_W-1:CLIENT_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept_in     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      rate_q     <= RATE_RESET;
      burst_q    <= BURST_RESET;
      rate_eff_q <= RATE_RESET;
      cap_q      <= CAP_RESET;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MODE:  mode_q  <= cfg_data_i[0];
          CFG_RATE:  rate_q  <= cfg_data_i[RATE_W-1:0];
          CFG_BURST: burst_q <= cfg_data_i[BURST_W-1:0];
          default: ;
        endcase
      end
      // zero rate acts as one; both settle long before the refill unit reads them
      rate_eff_q <= (rate_q == '0) ? RATE_W'(1) : rate_q;
      cap_q      <= cap_from_burst(burst_q);
    end
  end

  // ---------------------------------------------------------------- control fsm
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_in) begin
          if (!mode_q) begin
            state_d = ST_SHARED;
          end else if (in_client[CLIENT_W-1]) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_cmp && (hit || scan_last)) state_d = ST_BUCKET;
      end
      ST_SHARED: state_d = ST_BUCKET;
      ST_BUCKET: begin
        if (rf_done) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- table scan
  assign probe_nxt  = (probe_q == SLOT_IDX_W'(TABLE_SLOTS - 1)) ? '0 : probe_q + 1'b1;
  assign scan_issue = (state_q == ST_SCAN) && (issue_cnt_q != SLOT_CNT_W'(TABLE_SLOTS));
  assign scan_cmp   = (state_q == ST_SCAN) && rd_vld_q;
  assign rd_entry   = slot_entry_t'(ram_rdata);

  assign hit        = scan_cmp && rd_used_q && (rd_entry.client == id_q[CLIENT_KEY_W-1:0]);
  assign scan_last  = scan_cmp && (cmp_cnt_q == SLOT_CNT_W'(TABLE_SLOTS - 1));
  assign empty_take = !have_empty_q && !rd_used_q;
  // eviction candidate: most tokens among used slots, first in probe order on ties
  assign best_take  = rd_used_q && (!have_best_q || (rd_entry.tokens > best_tok_q));

  always_comb begin
    if (have_empty_q) begin
      new_slot = empty_slot_q;
    end else if (empty_take || best_take) begin
      new_slot = rd_slot_q;
    end else begin
      new_slot = best_slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_pc_q    <= 1'b0;
      issue_cnt_q  <= '0;
      cmp_cnt_q    <= '0;
      rd_vld_q     <= 1'b0;
      have_empty_q <= 1'b0;
      have_best_q  <= 1'b0;
      used_q       <= '0;
    end else begin
      rd_vld_q <= scan_issue;
      if (accept_in) begin
        item_pc_q    <= mode_q;
        issue_cnt_q  <= '0;
        cmp_cnt_q    <= '0;
        have_empty_q <= 1'b0;
        have_best_q  <= 1'b0;
      end
      if (scan_issue) begin
        issue_cnt_q <= issue_cnt_q + 1'b1;
      end
      if (scan_cmp) begin
        cmp_cnt_q <= cmp_cnt_q + 1'b1;
        if (empty_take) have_empty_q <= 1'b1;
        if (best_take)  have_best_q  <= 1'b1;
      end
      if (ram_we) begin
        used_q[tgt_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      id_q    <= in_client;
      now_q   <= in_now;
      // probing starts at the id modulo TABLE_SLOTS, the low id bits
      probe_q <= in_client[SLOT_IDX_W-1:0];
    end
    if (scan_issue) begin
      probe_q   <= probe_nxt;
      rd_slot_q <= probe_q;
      rd_used_q <= used_q[probe_q];
    end
    if (scan_cmp) begin
      if (empty_take) empty_slot_q <= rd_slot_q;
      if (best_take) begin
        best_tok_q  <= rd_entry.tokens;
        best_slot_q <= rd_slot_q;
      end
      if (hit || scan_last) begin
        tgt_q <= hit ? rd_slot_q : new_slot;
      end
    end
  end

  // one request at a time: the write-back of an entry finishes before the next scan reads
  pctbl_ram #(
    .Depth (TABLE_SLOTS),
    .Width (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tgt_q),
    .wdata_i (ram_wdata),
    .re_i    (scan_issue),
    .raddr_i (probe_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- refill
  assign rf_start = (state_q == ST_SHARED) || (scan_cmp && (hit || scan_last));

  always_comb begin
    rf_req.now = now_q;
    if (state_q == ST_SHARED) begin
      rf_req.tokens = shared_tok_q;
      rf_req.last   = shared_last_q;
    end else if (hit) begin
      rf_req.tokens = rd_entry.tokens;
      rf_req.last   = rd_entry.last;
    end else begin
      // new client: full bucket, last refill now
      rf_req.tokens = cap_q;
      rf_req.last   = now_q;
    end
  end

  pctbl_refill u_refill (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rf_start),
    .req_i   (rf_req),
    .rate_i  (rate_eff_q),
    .cap_i   (cap_q),
    .done_o  (rf_done),
    .res_o   (rf_res)
  );

  assign ram_we           = rf_done && item_pc_q;
  assign ram_wdata.client = id_q[CLIENT_KEY_W-1:0];
  assign ram_wdata.tokens = rf_res.tokens;
  assign ram_wdata.last   = rf_res.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shared_tok_q  <= CAP_RESET;
      shared_last_q <= '0;
    end else if (rf_done && !item_pc_q) begin
      shared_tok_q  <= rf_res.tokens;
      shared_last_q <= rf_res.last;
    end
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      // negative id in per-client mode is granted outright
      res_grant_q <= 1'b1;
    end
    if (rf_done) begin
      res_grant_q <= rf_res.granted;
    end
  end

  assign out_load = (state_q == ST_RESP) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_grant_q <= res_grant_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - 1)'(0), out_grant_q};

endmodule

@@ rtl/pctbl_checker.sv @@
// port-level checker of the token bucket limiter and its bind
`include "per_client_token_bucket_limiter_core_macros.svh"

module pctbl_checker import pctbl_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // stalled result holds
  `PCTBL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // one request in flight
  `PCTBL_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")

  // padding above the grant bit
  `PCTBL_ASSERT(a_pad_zero, m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:1] == '0), "nonzero result padding")

  // a result only appears while a request is being worked on
  `PCTBL_ASSERT(a_result_after_work, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "result without pending request")

endmodule

bind per_client_token_bucket_limiter_core pctbl_checker u_pctbl_checker (.*);

@@ tb/per_client_token_bucket_limiter_core_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench of the per-client token bucket limiter core
module per_client_token_bucket_limiter_core_tb;
  import pctbl_pkg::*;

  localparam int unsigned   QUIET_LIMIT   = 5000;  // cycles with no transaction at all
  localparam int unsigned   STALL_CYCLES  = 400;   // long receiver hold-off
  localparam int unsigned   SETTLE_CYCLES = 100;   // idle wait before the final verdict
  localparam logic [63:0]   NANO          = 64'd1_000_000_000;
  localparam logic [63:0]   ALL_ONES      = '1;

  logic                   clk_i  = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [16:0] client_id, [80:17] now_ns
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [0] granted
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  per_client_token_bucket_limiter_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // expected verdict, with the request kept for the mismatch report
  typedef struct packed {
    logic                granted;
    logic [CLIENT_W-1:0] client;
    logic [TIME_W-1:0]   now;
  } grant_exp_t;

  grant_exp_t expected_grants[$];

  int unsigned error_count   = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned src_idle_pct  = 34;
  int unsigned sink_idle_pct = 34;
  logic        hold_output   = 1'b0;
  logic [63:0] now_base      = '0;

  // shadow of the configuration and the buckets
  logic                    cur_per_client;
  logic [RATE_W-1:0]       cur_rate;
  logic [BURST_W-1:0]      cur_burst;
  logic [63:0]             shared_tok;
  logic [63:0]             shared_last;
  logic                    slot_used [TABLE_SLOTS];
  logic [CLIENT_KEY_W-1:0] slot_key  [TABLE_SLOTS];
  logic [63:0]             slot_tok  [TABLE_SLOTS];
  logic [63:0]             slot_last [TABLE_SLOTS];

  function automatic logic [63:0] bucket_cap();
    return ((cur_burst == '0) ? 64'd1 : 64'(cur_burst)) * NANO;
  endfunction

  function automatic int unsigned token_period();
    return 32'd1_000_000_000 / ((cur_rate == '0) ? 32'd1 : 32'(cur_rate));
  endfunction

  // refill one bucket up to now, then take a whole token if there is one;
  // a negative slot selects the shared bucket
  function automatic logic draw_token(input int slot, input logic [63:0] now);
    logic [63:0] tok;
    logic [63:0] last;
    logic [63:0] rate;
    logic [63:0] elapsed;
    logic        granted;
    tok  = (slot < 0) ? shared_tok : slot_tok[slot];
    last = (slot < 0) ? shared_last : slot_last[slot];
    if (now > last) begin
      rate    = (cur_rate == '0) ? 64'd1 : 64'(cur_rate);
      elapsed = now - last;
      // the product saturates at the cap
      if (elapsed > (ALL_ONES - tok) / rate) tok = bucket_cap();
      else tok = tok + elapsed * rate;
      if (tok > bucket_cap()) tok = bucket_cap();
      last = now;
    end
    granted = (tok >= NANO);
    if (granted) tok = tok - NANO;
    if (slot < 0) begin
      shared_tok  = tok;
      shared_last = last;
    end else begin
      slot_tok[slot]  = tok;
      slot_last[slot] = last;
    end
    return granted;
  endfunction

  function automatic logic predict_grant(input logic [CLIENT_W-1:0] client,
                                         input logic [63:0] now);
    logic [CLIENT_KEY_W-1:0] key;
    int                      home;
    int                      s;
    int                      hit;
    int                      free_slot;
    logic [63:0]             most;
    if (!cur_per_client) return draw_token(-1, now);
    // negative id: granted, nothing stored
    if (client[CLIENT_W-1]) return 1'b1;
    key       = client[CLIENT_KEY_W-1:0];
    home      = int'(key) % TABLE_SLOTS;
    hit       = -1;
    free_slot = -1;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      s = (home + i) % TABLE_SLOTS;
      if (slot_used[s] && slot_key[s] == key) begin
        hit = s;
        break;
      end
      if (!slot_used[s] && free_slot < 0) free_slot = s;
    end
    if (hit >= 0) return draw_token(hit, now);
    // table full: evict the fullest bucket, first in probe order on a tie
    if (free_slot < 0) begin
      free_slot = home;
      most      = slot_tok[home];
      for (int i = 1; i < TABLE_SLOTS; i++) begin
        s = (home + i) % TABLE_SLOTS;
        if (slot_tok[s] > most) begin
          most      = slot_tok[s];
          free_slot = s;
        end
      end
    end
    slot_used[free_slot] = 1'b1;
    slot_key[free_slot]  = key;
    slot_tok[free_slot]  = bucket_cap();
    slot_last[free_slot] = now;
    return draw_token(free_slot, now);
  endfunction

  // one request transaction, with random idle cycles ahead of it
  task automatic send_request(input logic [CLIENT_W-1:0] client, input logic [TIME_W-1:0] now);
    grant_exp_t item;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({now, client});
    do @(posedge clk_i); while (!s_axis_tready);
    item.client  = client;
    item.now     = now;
    item.granted = predict_grant(client, now);
    expected_grants.push_back(item);
  endtask

  // timestamps walk forward with an occasional stale one
  task automatic send_timed(input logic [CLIENT_W-1:0] client, input int unsigned step_max);
    logic [TIME_W-1:0] now;
    if ($urandom_range(19) == 0) begin
      now = now_base - $urandom_range(step_max);
    end else begin
      now_base = now_base + $urandom_range(step_max);
      now      = now_base;
    end
    send_request(client, now);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk_i);
  endtask

  // valid stays high across back-to-back writes
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MODE:  cur_per_client = value[0];
      CFG_RATE:  cur_rate = value[RATE_W-1:0];
      CFG_BURST: cur_burst = value[BURST_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic mode, input logic [RATE_W-1:0] rate,
                           input logic [BURST_W-1:0] burst);
    wait_idle();
    write_reg(CFG_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_RATE, CFG_DATA_W'(rate));
    write_reg(CFG_BURST, CFG_DATA_W'(burst));
    cfg_valid_i <= 1'b0;
  endtask

  // shared bucket: id ignored, lowered burst, clamp, deny, zero rate and burst, stale time
  task automatic test_shared_bucket_directed();
    send_request(17'h1FFFF, 64'd0);
    send_request(17'h10000, 64'd0);
    send_request(17'h0FFFF, 64'd0);
    configure(1'b0, 20'd100, 16'd2);
    send_request(17'd0, 64'd0);
    send_request(17'd5, 64'd1);
    send_request(17'd5, 64'd1);
    send_request(17'd5, 64'd1);
    configure(1'b0, 20'd0, 16'd0);
    send_request(17'd7, 64'd1_000_000_000);
    send_request(17'd7, 64'd1_000_000_001);
    send_request(17'd7, 64'd1_000_000_001);
    send_request(17'd7, 64'd500);
    now_base = 64'd2_000_000_000;
  endtask

  // client table: negative ids, new clients, probe collisions, product saturation
  task automatic test_client_table_directed();
    configure(1'b1, 20'hFFFFF, 16'hFFFF);
    send_request(17'h1FFFF, 64'd0);
    send_request(17'h1A5A5, 64'd0);
    send_request(17'd0, now_base);
    send_request(17'd64, now_base);
    send_request(17'd128, now_base);
    send_request(17'd64, now_base);
    send_request(17'h0FFFF, 64'd100);
    send_request(17'h0FFFF, ALL_ONES);
    send_request(17'd1, now_base);
  endtask

  task automatic test_shared_bucket_random(input logic [RATE_W-1:0] rate,
                                           input logic [BURST_W-1:0] burst,
                                           input int unsigned count);
    configure(1'b0, rate, burst);
    repeat (count) send_timed(17'($urandom), 2 * token_period());
  endtask

  // pool ids crowd into a few home slots; pools over the slot count force evictions
  task automatic test_client_table_random(input logic [RATE_W-1:0] rate,
                                          input logic [BURST_W-1:0] burst,
                                          input int unsigned pool_size,
                                          input int unsigned count);
    logic [CLIENT_KEY_W-1:0] pool [128];
    logic [CLIENT_W-1:0]     client;
    int unsigned             pick;
    configure(1'b1, rate, burst);
    for (int n = 0; n < pool_size; n++) begin
      pool[n] = {10'($urandom),
                 ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(3))};
    end
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 5) client = {1'b1, 16'($urandom)};
      else if (pick < 10) client = {1'b0, 16'($urandom)};
      else client = {1'b0, pool[$urandom_range(pool_size - 1)]};
      send_timed(client, 2 * token_period() / pool_size);
    end
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_output_backpressure();
    configure(1'b0, 20'd1_000_000, 16'hFFFF);
    src_idle_pct = 0;
    hold_output  = 1'b1;
    repeat (16) send_timed(17'($urandom), 2 * token_period());
    src_idle_pct = 34;
  endtask

  // full-width timestamps, last because they pin refill times near the top
  task automatic test_wide_timestamps();
    logic [CLIENT_KEY_W-1:0] pool [6];
    configure(1'b1, 20'd777, 16'd4);
    foreach (pool[n]) pool[n] = 16'($urandom);
    repeat (40) send_request({1'b0, pool[$urandom_range(5)]}, {$urandom, $urandom});
    configure(1'b0, 20'hFFFFF, 16'hFFFF);
    repeat (20) send_request(17'($urandom), {$urandom, $urandom});
  endtask

  // receiver ready, with the long hold-off counted here
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_output) begin
        m_axis_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk_i);
        hold_output = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_grants.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual granted=%0b",
                 $time, m_axis_tdata[0]);
      end else if (m_axis_tdata[0] !== expected_grants[0].granted) begin
        error_count++;
        $display("%0t: granted mismatch for client 0x%05h at %0d ns, expected %0b actual %0b",
                 $time, expected_grants[0].client, expected_grants[0].now,
                 expected_grants[0].granted, m_axis_tdata[0]);
        void'(expected_grants.pop_front());
      end else begin
        void'(expected_grants.pop_front());
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_grants.size());
      $display("** per_client_token_bucket_limiter_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_MODE;
    cfg_data_i    = '0;
    // shadow state as after reset
    cur_per_client = 1'b0;
    cur_rate       = RATE_RESET;
    cur_burst      = BURST_RESET;
    shared_tok     = bucket_cap();
    shared_last    = '0;
    foreach (slot_used[s]) slot_used[s] = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_shared_bucket_directed();
    test_client_table_directed();
    test_shared_bucket_random(20'd1, 16'd1, 130);
    test_shared_bucket_random(20'd1_000_000, 16'd3, 130);
    test_shared_bucket_random(20'd5000, 16'hFFFF, 130);
    test_client_table_random(20'd1000, 16'd3, 20, 150);
    test_client_table_random(20'd1, 16'd1, 64, 150);
    test_client_table_random(20'hFFFFF, 16'd7, 90, 180);
    // long stretch with neither side idling
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_client_table_random(20'd0, 16'd0, 90, 200);
    src_idle_pct  = 34;
    sink_idle_pct = 34;
    test_output_backpressure();
    test_wide_timestamps();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** per_client_token_bucket_limiter_core: PASSED **");
    end else begin
      $display("** per_client_token_bucket_limiter_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pctbl_pkg.sv
rtl/pctbl_ram.sv
rtl/pctbl_refill.sv
rtl/per_client_token_bucket_limiter_core.sv
rtl/pctbl_checker.sv
tb/per_client_token_bucket_limiter_core_tb.sv
